>>> rtl/hms_pkg.sv
// Shared types, constants and byte classifiers for the header marker stripper.
// No dependencies; every other file but hms_if.sv refers to this package by scoped names.
package hms_pkg;

  localparam int NUM_HEADERS    = 2;
  localparam int REG_HEADERS    = 2;
  localparam int NUM_MARKERS    = 2 * NUM_HEADERS;
  localparam int MAX_MARKER_LEN = 8;
  localparam int HOLD_DEPTH     = 32;
  localparam int CMDQ_DEPTH     = 2;
  localparam int OUTQ_DEPTH     = 2;

  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W      = $clog2(HOLD_DEPTH);
  localparam int LEN_W      = $clog2(MAX_MARKER_LEN + 1);
  localparam int NIB_W      = 4;
  localparam int MK_IDX_W   = $clog2(NUM_MARKERS);
  localparam int HDR_W      = $clog2(NUM_HEADERS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LENS_W     = 16;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_MARKER_LEN-1:0] marker_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ENABLE  = 3'd0,
    REG_OPEN_A         = 3'd1,
    REG_CLOSE_A        = 3'd2,
    REG_OPEN_B         = 3'd3,
    REG_CLOSE_B        = 3'd4,
    REG_MARKER_LENGTHS = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_DATA,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    byte_t     data;
  } cmd_t;

  typedef struct packed {
    marker_t [NUM_MARKERS-1:0]            bytes;
    logic    [NUM_MARKERS-1:0][LEN_W-1:0] len;
  } mk_set_t;

  typedef struct packed {
    byte_t out_byte;
    logic  run_last;
  } res_t;

  function automatic logic is_ident(byte_t b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDERSCORE || b == CH_HYPHEN;
  endfunction

  function automatic logic is_space(byte_t b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

endpackage

>>> rtl/hms_if.sv
// Valid/ready channel interfaces for the input words and the result words.
// Depends on nothing.
interface hms_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface hms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

>>> rtl/hms_cfg_regs.sv
// Configuration registers and the derived marker table (clamped lengths).
// Depends on hms_pkg.
module hms_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hms_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [hms_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                filter_en,
  output hms_pkg::mk_set_t                    markers
);

  logic                             en_r;
  logic [hms_pkg::CFG_DATA_W-1:0]   mk_r [2*hms_pkg::REG_HEADERS];
  logic [hms_pkg::LENS_W-1:0]       lens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      lens_r <= '0;
      for (int k = 0; k < 2*hms_pkg::REG_HEADERS; k++) mk_r[k] <= '0;
    end else if (cfg_we) begin
      unique case (hms_pkg::cfg_reg_t'(cfg_idx))
        hms_pkg::REG_FILTER_ENABLE:  en_r   <= cfg_wdata[0];
        hms_pkg::REG_OPEN_A:         mk_r[0] <= cfg_wdata;
        hms_pkg::REG_CLOSE_A:        mk_r[1] <= cfg_wdata;
        hms_pkg::REG_OPEN_B:         mk_r[2] <= cfg_wdata;
        hms_pkg::REG_CLOSE_B:        mk_r[3] <= cfg_wdata;
        hms_pkg::REG_MARKER_LENGTHS: lens_r <= cfg_wdata[hms_pkg::LENS_W-1:0];
        default: ;
      endcase
    end
  end

  assign filter_en = en_r;

  always_comb begin
    logic [hms_pkg::NIB_W-1:0] nib;
    markers = '0;
    nib = '0;
    for (int k = 0; k < hms_pkg::NUM_MARKERS; k++) begin
      if (k < 2*hms_pkg::REG_HEADERS) begin
        nib = lens_r[hms_pkg::NIB_W*k +: hms_pkg::NIB_W];
        markers.bytes[k] = mk_r[k];
        markers.len[k] = (nib > hms_pkg::NIB_W'(hms_pkg::MAX_MARKER_LEN)) ?
                         hms_pkg::LEN_W'(hms_pkg::MAX_MARKER_LEN) : hms_pkg::LEN_W'(nib);
      end
    end
  end

endmodule

>>> rtl/hms_front.sv
// Front end: accepts input words, classifies them and queues commands.
// Depends on hms_pkg and hms_in_if.
module hms_front (
  input  logic             clk,
  input  logic             rst_n,
  hms_in_if.sink           in_chan,
  input  logic             filter_en,
  output hms_pkg::cmd_t    cmd,
  output logic             cmd_valid,
  input  logic             cmd_pop
);

  localparam int QA_W = $clog2(hms_pkg::CMDQ_DEPTH);
  localparam int QN_W = $clog2(hms_pkg::CMDQ_DEPTH + 1);

  hms_pkg::cmd_t   q_r [hms_pkg::CMDQ_DEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QN_W-1:0] n_r;
  logic            accept, push;
  hms_pkg::cmd_t   new_cmd;

  assign in_chan.ready = (n_r != QN_W'(hms_pkg::CMDQ_DEPTH));
  assign accept = in_chan.valid && in_chan.ready;
  // disabled flush produces nothing
  assign push = accept && (filter_en || in_chan.op != hms_pkg::OP_FLUSH);

  always_comb begin
    new_cmd.data = in_chan.data_byte;
    if (!filter_en) new_cmd.kind = hms_pkg::CMD_PASS;
    else if (in_chan.op == hms_pkg::OP_FLUSH) new_cmd.kind = hms_pkg::CMD_FLUSH;
    else new_cmd.kind = hms_pkg::CMD_DATA;
  end

  assign cmd = q_r[rp_r];
  assign cmd_valid = (n_r != '0);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= new_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      if (push) wp_r <= wp_r + QA_W'(1);
      if (cmd_pop) rp_r <= rp_r + QA_W'(1);
      n_r <= n_r + QN_W'(push) - QN_W'(cmd_pop);
    end
  end

endmodule

>>> rtl/hms_back.sv
// Back end: hold buffer and the scan sequencer that strips markups.
// Works on the buffer head; whitespace after a name is looked past by rotation.
// Depends on hms_pkg.
module hms_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hms_pkg::cmd_t    cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  hms_pkg::mk_set_t markers,
  output hms_pkg::res_t    res,
  output logic             res_push,
  input  logic             res_full
);

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_WS, ST_RESTORE, ST_FIN} state_t;
  typedef enum logic [1:0] {B_HOLD, B_POP, B_ROT, B_APPEND} buf_op_t;

  state_t                         state_r, state_nxt;
  logic                           phase_r, phase_nxt;
  logic [hms_pkg::HDR_W-1:0]      cur_r, cur_nxt;
  logic                           end_r, end_nxt;
  logic                           post_r, post_nxt;
  logic [hms_pkg::CNT_W-1:0]      rot_r, rot_nxt;
  logic [hms_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           pend_v_r, pend_v_nxt;
  hms_pkg::byte_t                 pend_b_r, pend_b_nxt;
  hms_pkg::byte_t                 buf_r [hms_pkg::HOLD_DEPTH];
  hms_pkg::byte_t                 buf_nxt [hms_pkg::HOLD_DEPTH];

  buf_op_t                        buf_op;
  logic [hms_pkg::LEN_W-1:0]      pop_n;
  logic                           emit_v;
  hms_pkg::byte_t                 emit_b;

  logic [hms_pkg::MAX_MARKER_LEN-1:0][hms_pkg::NUM_MARKERS-1:0] full_at;
  logic                           head_any, any_full, part0;
  logic [hms_pkg::MK_IDX_W-1:0]   head_k;
  logic [hms_pkg::LEN_W-1:0]      head_len;
  logic [hms_pkg::MK_IDX_W-1:0]   cidx;
  hms_pkg::marker_t               cm;
  logic [hms_pkg::LEN_W-1:0]      cl;
  logic [hms_pkg::CNT_W-1:0]      rem;
  logic                           c_eq_ok, c_pre_ok, c_match, c_wait;

  // full marker matches at the first window positions
  always_comb begin
    logic ok;
    for (int q = 0; q < hms_pkg::MAX_MARKER_LEN; q++) begin
      for (int k = 0; k < hms_pkg::NUM_MARKERS; k++) begin
        ok = (markers.len[k] != '0) && (q + int'(markers.len[k]) <= int'(cnt_r));
        for (int i = 0; i < hms_pkg::MAX_MARKER_LEN; i++) begin
          if (i < int'(markers.len[k]) && buf_r[q+i] != markers.bytes[k][i]) ok = 1'b0;
        end
        full_at[q][k] = ok;
      end
    end
  end

  always_comb begin
    logic p;
    head_any = |full_at[0];
    any_full = |full_at;
    head_k = '0;
    for (int k = hms_pkg::NUM_MARKERS - 1; k >= 0; k--) begin
      if (full_at[0][k]) head_k = hms_pkg::MK_IDX_W'(k);
    end
    head_len = markers.len[head_k];
    // whole buffer is a proper prefix of some marker
    part0 = 1'b0;
    for (int k = 0; k < hms_pkg::NUM_MARKERS; k++) begin
      p = int'(cnt_r) < int'(markers.len[k]);
      for (int i = 0; i < hms_pkg::MAX_MARKER_LEN; i++) begin
        if (i < int'(cnt_r) && buf_r[i] != markers.bytes[k][i]) p = 1'b0;
      end
      part0 = part0 | p;
    end
  end

  // close marker of the open header, checked at the head
  assign cidx = {cur_r, 1'b1};
  assign cm   = markers.bytes[cidx];
  assign cl   = markers.len[cidx];
  assign rem  = cnt_r - rot_r;

  always_comb begin
    c_eq_ok  = 1'b1;
    c_pre_ok = 1'b1;
    for (int i = 0; i < hms_pkg::MAX_MARKER_LEN; i++) begin
      if (i < int'(cl) && buf_r[i] != cm[i]) c_eq_ok = 1'b0;
      if (i < int'(rem) && buf_r[i] != cm[i]) c_pre_ok = 1'b0;
    end
  end

  assign c_match = (cl != '0) && (rem >= hms_pkg::CNT_W'(cl)) && c_eq_ok;
  assign c_wait  = (cl != '0) && !end_r && (rem < hms_pkg::CNT_W'(cl)) && c_pre_ok;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    end_nxt    = end_r;
    post_nxt   = post_r;
    rot_nxt    = rot_r;
    cnt_nxt    = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_b_nxt = pend_b_r;
    buf_op     = B_HOLD;
    pop_n      = '0;
    emit_v     = 1'b0;
    emit_b     = buf_r[0];
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    if (!res_full) begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_pop = 1'b1;
            unique case (cmd.kind)
              hms_pkg::CMD_PASS: begin
                res_push = 1'b1;
                res.out_byte = cmd.data;
                res.run_last = 1'b1;
              end
              hms_pkg::CMD_DATA: begin
                end_nxt = 1'b0;
                state_nxt = ST_SCAN;
                if (cnt_r < hms_pkg::CNT_W'(hms_pkg::HOLD_DEPTH)) begin
                  buf_op = B_APPEND;
                  cnt_nxt = cnt_r + hms_pkg::CNT_W'(1);
                end
              end
              hms_pkg::CMD_FLUSH: begin
                end_nxt = 1'b1;
                state_nxt = ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (!phase_r) begin
            if (cnt_r == '0) begin
              state_nxt = ST_FIN;
            end else if (head_any) begin
              buf_op = B_POP;
              pop_n = head_len;
              cnt_nxt = cnt_r - hms_pkg::CNT_W'(head_len);
              if (!head_k[0]) begin
                phase_nxt = 1'b1;
                cur_nxt = head_k[hms_pkg::MK_IDX_W-1:1];
              end
            end else if (!end_r && !any_full && part0) begin
              state_nxt = ST_FIN;
            end else begin
              emit_v = 1'b1;
              buf_op = B_POP;
              pop_n = hms_pkg::LEN_W'(1);
              cnt_nxt = cnt_r - hms_pkg::CNT_W'(1);
            end
          end else begin
            if (cnt_r == '0) begin
              if (end_r) phase_nxt = 1'b0;
              else state_nxt = ST_FIN;
            end else if (hms_pkg::is_ident(buf_r[0])) begin
              buf_op = B_POP;
              pop_n = hms_pkg::LEN_W'(1);
              cnt_nxt = cnt_r - hms_pkg::CNT_W'(1);
            end else begin
              rot_nxt = '0;
              state_nxt = ST_WS;
            end
          end
        end
        ST_WS: begin
          if (rot_r == cnt_r) begin
            // all whitespace; rotation came full circle
            if (end_r || cnt_r >= hms_pkg::CNT_W'(hms_pkg::HOLD_DEPTH)) begin
              phase_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end else begin
              state_nxt = ST_FIN;
            end
          end else if (hms_pkg::is_space(buf_r[0])) begin
            buf_op = B_ROT;
            rot_nxt = rot_r + hms_pkg::CNT_W'(1);
          end else if (c_match) begin
            // close at head, rotated whitespace sits at the tail
            buf_op = B_POP;
            pop_n = cl;
            cnt_nxt = cnt_r - hms_pkg::CNT_W'(cl) - rot_r;
            phase_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else begin
            post_nxt = !c_wait || cnt_r >= hms_pkg::CNT_W'(hms_pkg::HOLD_DEPTH);
            state_nxt = ST_RESTORE;
          end
        end
        ST_RESTORE: begin
          if (rot_r == cnt_r) begin
            if (post_r) begin
              phase_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end else begin
              state_nxt = ST_FIN;
            end
          end else begin
            buf_op = B_ROT;
            rot_nxt = rot_r + hms_pkg::CNT_W'(1);
          end
        end
        ST_FIN: begin
          if (pend_v_r) begin
            res_push = 1'b1;
            res.out_byte = pend_b_r;
            res.run_last = 1'b1;
          end
          pend_v_nxt = 1'b0;
          if (end_r) begin
            cnt_nxt = '0;
            phase_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_IDLE;
      endcase
      // one word of delay so the last word of a step can be marked
      if (emit_v) begin
        if (pend_v_r) begin
          res_push = 1'b1;
          res.out_byte = pend_b_r;
          res.run_last = 1'b0;
        end
        pend_v_nxt = 1'b1;
        pend_b_nxt = emit_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= 1'b0;
      cur_r    <= '0;
      end_r    <= 1'b0;
      post_r   <= 1'b0;
      rot_r    <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      cur_r    <= cur_nxt;
      end_r    <= end_nxt;
      post_r   <= post_nxt;
      rot_r    <= rot_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_b_r <= pend_b_nxt;
  end

  always_comb begin
    buf_nxt = buf_r;
    unique case (buf_op)
      B_POP: begin
        for (int i = 0; i < hms_pkg::HOLD_DEPTH; i++) begin
          for (int n = 1; n <= hms_pkg::MAX_MARKER_LEN; n++) begin
            if (int'(pop_n) == n && i + n < hms_pkg::HOLD_DEPTH)
              buf_nxt[i] = buf_r[(i + n) % hms_pkg::HOLD_DEPTH];
          end
        end
      end
      B_ROT: begin
        for (int i = 0; i < hms_pkg::HOLD_DEPTH; i++) begin
          if (hms_pkg::CNT_W'(i) == cnt_r - hms_pkg::CNT_W'(1)) buf_nxt[i] = buf_r[0];
          else if (i < hms_pkg::HOLD_DEPTH - 1)
            buf_nxt[i] = buf_r[(i + 1) % hms_pkg::HOLD_DEPTH];
        end
      end
      B_APPEND: buf_nxt[cnt_r[hms_pkg::IDX_W-1:0]] = cmd.data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

>>> rtl/hms_out_buf.sv
// Two-word result queue driving the output channel.
// Depends on hms_pkg and hms_out_if.
module hms_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  hms_pkg::res_t  res,
  input  logic           res_push,
  output logic           res_full,
  hms_out_if.source      out_chan
);

  localparam int QA_W = $clog2(hms_pkg::OUTQ_DEPTH);
  localparam int QN_W = $clog2(hms_pkg::OUTQ_DEPTH + 1);

  hms_pkg::res_t   q_r [hms_pkg::OUTQ_DEPTH];
  logic [QA_W-1:0] wp_r, rp_r;
  logic [QN_W-1:0] n_r;
  logic            pop;

  assign res_full = (n_r == QN_W'(hms_pkg::OUTQ_DEPTH));
  assign out_chan.valid = (n_r != '0);
  assign out_chan.out_byte = q_r[rp_r].out_byte;
  assign out_chan.run_last = q_r[rp_r].run_last;
  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (res_push) q_r[wp_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      if (res_push) wp_r <= wp_r + QA_W'(1);
      if (pop) rp_r <= rp_r + QA_W'(1);
      n_r <= n_r + QN_W'(res_push) - QN_W'(pop);
    end
  end

endmodule

>>> rtl/header_marker_stripper_top.sv
// Header marker stripper: removes header markups from a byte stream.
// Disabled: a byte passes through the command queue, then the result queue, one byte every
// cycle while the output takes them. Enabled: a word is taken, then each scan step emits a
// byte or drops a name byte or a marker, then a closing step; whitespace after a name is
// passed by rotating the hold buffer a place at a time. A word ends before the next is taken.
// Reset clears control and configuration; hold buffer contents stay undefined until written.
module header_marker_stripper_top (
  input  logic                            clk,
  input  logic                            rst_n,
  hms_in_if.sink                          in_chan,
  hms_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [hms_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [hms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic             filter_en;
  hms_pkg::mk_set_t markers;
  hms_pkg::cmd_t    cmd;
  logic             cmd_valid, cmd_pop;
  hms_pkg::res_t    res;
  logic             res_push, res_full;

  hms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .filter_en (filter_en),
    .markers   (markers)
  );

  hms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .filter_en (filter_en),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  hms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .markers   (markers),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  hms_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full),
    .out_chan (out_chan)
  );

endmodule
